// ===== hdl/acfb_pkg.sv =====
// ----------------------------------------------------------------------------
// acfb_pkg: shared types, constants and functions of the AES-128 CFB block
// Holds the S-box, round helpers, configuration register codes and structs.
// ----------------------------------------------------------------------------
package acfb_pkg;

  localparam int ROUND_COUNT = 10;
  localparam int KEY_WORDS   = 2 * (ROUND_COUNT + 1);
  localparam int KA_W        = $clog2(KEY_WORDS);
  localparam int RND_W       = $clog2(ROUND_COUNT + 1);

  localparam logic [2:0] REG_KEY_LOW  = 3'd0;
  localparam logic [2:0] REG_KEY_HIGH = 3'd1;
  localparam logic [2:0] REG_IV_LOW   = 3'd2;
  localparam logic [2:0] REG_IV_HIGH  = 3'd3;
  localparam logic [2:0] REG_DECRYPT  = 3'd4;

  localparam logic [7:0] RCON_FIRST = 8'h01;
  localparam logic [7:0] XT_POLY    = 8'h1B;

  typedef struct packed {
    logic [63:0] result_low;
    logic [63:0] result_high;
    logic [4:0]  result_count;
  } res_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
      8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
      8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
      8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
      8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
      8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
      8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
      8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
      8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
      8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
      8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
      8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
      8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
      8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
      8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
      8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? XT_POLY : 8'h00);
  endfunction

  // One keyless AES round on a 128-bit state, byte i in bits 8i+7:8i.
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic mix);
    logic [7:0] t [16];
    logic [127:0] o;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[4*c+r] = sbox(s[8*(4*((c+r)%4)+r) +: 8]);
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      if (mix) begin
        o[8*(4*c)   +: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
        o[8*(4*c+1) +: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
        o[8*(4*c+2) +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
        o[8*(4*c+3) +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end else begin
        o[8*(4*c) +: 32] = {a3, a2, a1, a0};
      end
    end
    return o;
  endfunction

  // Next round key from the previous one.
  function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] t;
    logic [127:0] o;
    t = {sbox(k[103:96]), sbox(k[127:120]), sbox(k[119:112]), sbox(k[111:104]) ^ rc};
    o[31:0]   = k[31:0]   ^ t;
    o[63:32]  = k[63:32]  ^ o[31:0];
    o[95:64]  = k[95:64]  ^ o[63:32];
    o[127:96] = k[127:96] ^ o[95:64];
    return o;
  endfunction

endpackage

// ===== hdl/acfb_stream_if.sv =====
// ----------------------------------------------------------------------------
// acfb_in_if / acfb_out_if: valid/ready channels of the CFB block
// Input carries one data block request, output one result request.
// ----------------------------------------------------------------------------
interface acfb_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_low;
  logic [63:0] data_high;
  logic [4:0]  byte_count;
  logic        first_block;
  modport source (output valid, data_low, data_high, byte_count, first_block, input ready);
  modport sink   (input valid, data_low, data_high, byte_count, first_block, output ready);
endinterface

interface acfb_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_low;
  logic [63:0] result_high;
  logic [4:0]  result_count;
  modport source (output valid, result_low, result_high, result_count, input ready);
  modport sink   (input valid, result_low, result_high, result_count, output ready);
endinterface

// ===== hdl/acfb_ram.sv =====
// ----------------------------------------------------------------------------
// acfb_ram: generic single-port synchronous RAM
// One write or read per cycle, read data registered.
// ----------------------------------------------------------------------------
module acfb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 22
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== hdl/aes128_cfb_cipher.sv =====
// ----------------------------------------------------------------------------
// aes128_cfb_cipher: AES-128 full-block CFB encrypt/decrypt engine
// Round keys live in a 22 x 64 RAM; one AES round is done per round key.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake      Payload
// in_      in   valid/ready    data_low, data_high, byte_count, first_block
// out_     out  valid/ready    result_low, result_high, result_count
// cfg_     in   write enable   index 0..4, 64-bit data
//
// A request is taken in IDLE, RUN reads the round keys and does the rounds,
// and DONE forms the result. The key RAM has one 64-bit port, so each round
// key is read as two halves, one per cycle.
// A first block adds a key expansion pass (EXP) that writes the RAM.
// Reset clears the control state, the registers and the feedback block.
// The result waits in an output register; a new request is taken while it
// waits, and the engine stalls only before writing a second result.
module aes128_cfb_cipher
  import acfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  acfb_in_if.sink     in_ch,
  acfb_out_if.source  out_ch
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXP  = 3'd1;
  localparam logic [2:0] ST_RUN  = 3'd2;
  localparam logic [2:0] ST_DONE = 3'd3;

  logic [127:0] key_r, iv_r, fb_r, fb_nxt;
  logic         dec_r;
  logic [2:0]   st_r, st_nxt;
  logic [KA_W:0] cnt_r, cnt_nxt;
  logic [127:0] ek_r, ek_nxt, s_r, s_nxt;
  logic [7:0]   rc_r, rc_nxt;
  logic [63:0]  klo_r, klo_nxt;
  logic [127:0] d_r, d_nxt;
  logic [4:0]   n_r, n_nxt;
  logic         ov_r, ov_nxt;
  res_t         res_r, res_nxt;

  logic         we;
  logic [KA_W-1:0] addr;
  logic [63:0]  wdata, rdata;
  logic [127:0] rk, o, fb_sel;
  logic [RND_W-1:0] rnd;

  acfb_ram #(.WIDTH(64), .DEPTH(KEY_WORDS)) u_keys (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));

  assign in_ch.ready       = (st_r == ST_IDLE);
  assign out_ch.valid      = ov_r;
  assign out_ch.result_low   = res_r.result_low;
  assign out_ch.result_high  = res_r.result_high;
  assign out_ch.result_count = res_r.result_count;

  // In a run, cnt goes 0..22 and reads words 0..21; read i-1 arrives at i.
  assign rk  = {rdata, klo_r};
  assign rnd = RND_W'((cnt_r - 1'b1) >> 1);

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; ek_nxt = ek_r; s_nxt = s_r; rc_nxt = rc_r;
    klo_nxt = klo_r; d_nxt = d_r; n_nxt = n_r; fb_nxt = fb_r; ov_nxt = ov_r;
    res_nxt = res_r; we = 1'b0; addr = cnt_r[KA_W-1:0]; wdata = '0;
    o = '0; fb_sel = '0;
    if (out_ch.valid && out_ch.ready) begin
      ov_nxt = 1'b0;
    end
    unique case (st_r)
      ST_IDLE: begin
        addr = '0;
        if (in_ch.valid) begin
          d_nxt = {in_ch.data_high, in_ch.data_low};
          n_nxt = (in_ch.byte_count > 5'd16) ? 5'd16 : in_ch.byte_count;
          cnt_nxt = '0;
          if (in_ch.first_block) begin
            fb_nxt = iv_r; ek_nxt = key_r; rc_nxt = RCON_FIRST; st_nxt = ST_EXP;
          end else begin
            st_nxt = ST_RUN;
          end
        end
      end
      ST_EXP: begin
        we = 1'b1;
        wdata = cnt_r[0] ? ek_r[127:64] : ek_r[63:0];
        if (cnt_r[0]) begin
          ek_nxt = key_step(ek_r, rc_r);
          rc_nxt = xtime(rc_r);
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (KA_W+1)'(KEY_WORDS - 1)) begin
          cnt_nxt = '0; st_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r != '0) begin
          if (cnt_r[0]) begin
            klo_nxt = rdata;
          end else if (rnd == RND_W'(0)) begin
            s_nxt = fb_r ^ rk;
          end else begin
            s_nxt = aes_round(s_r, rnd != RND_W'(ROUND_COUNT)) ^ rk;
          end
        end
        if (cnt_r == (KA_W+1)'(KEY_WORDS)) begin
          st_nxt = ST_DONE;
        end
        if (cnt_r >= (KA_W+1)'(KEY_WORDS)) begin
          addr = '0;
        end
      end
      ST_DONE: begin
        addr = '0;
        if (!ov_nxt) begin
          for (int i = 0; i < 16; i++) begin
            if (5'(i) < n_r) begin
              o[8*i +: 8]      = d_r[8*i +: 8] ^ s_r[8*i +: 8];
              fb_sel[8*i +: 8] = dec_r ? d_r[8*i +: 8] : o[8*i +: 8];
            end
          end
          fb_nxt = fb_sel;
          res_nxt = '{result_low: o[63:0], result_high: o[127:64], result_count: n_r};
          ov_nxt = 1'b1;
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; cnt_r <= '0; ov_r <= 1'b0;
      key_r <= '0; iv_r <= '0; dec_r <= 1'b0; fb_r <= '0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; ov_r <= ov_nxt; fb_r <= fb_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_KEY_LOW:  key_r[63:0]   <= cfg_data;
          REG_KEY_HIGH: key_r[127:64] <= cfg_data;
          REG_IV_LOW:   iv_r[63:0]    <= cfg_data;
          REG_IV_HIGH:  iv_r[127:64]  <= cfg_data;
          REG_DECRYPT:  dec_r         <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    ek_r <= ek_nxt; s_r <= s_nxt; rc_r <= rc_nxt; klo_r <= klo_nxt;
    d_r <= d_nxt; n_r <= n_nxt; res_r <= res_nxt;
  end
endmodule

// ===== tb/acfb_cfb_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// acfb_cfb_checker: result predictor and comparator for the CFB block
// Tracks the register writes, predicts each result and checks it in order.
// ----------------------------------------------------------------------------
module acfb_cfb_checker
  import acfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  acfb_in_if          in_mon,
  acfb_out_if         out_mon,
  output int          fail_count,
  output int          results_owed
);

  localparam int BLOCK_BYTES = 16;

  logic [7:0] subst [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};

  logic [127:0] key_shadow, iv_shadow, chain_block;
  logic         decrypting;
  logic [127:0] round_keys [ROUND_COUNT + 1];
  res_t         owed_results [$];

  assign results_owed = owed_results.size();

  function automatic logic [7:0] gf_double(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
  endfunction

  task automatic expand_round_keys();
    logic [127:0] k;
    logic [7:0]   rc;
    logic [31:0]  t;
    k  = key_shadow;
    rc = 8'h01;
    round_keys[0] = k;
    for (int r = 1; r <= ROUND_COUNT; r++) begin
      t = {subst[k[103:96]], subst[k[127:120]], subst[k[119:112]],
           subst[k[111:104]] ^ rc};
      k[31:0]   = k[31:0]   ^ t;
      k[63:32]  = k[63:32]  ^ k[31:0];
      k[95:64]  = k[95:64]  ^ k[63:32];
      k[127:96] = k[127:96] ^ k[95:64];
      round_keys[r] = k;
      rc = gf_double(rc);
    end
  endtask

  function automatic logic [127:0] encrypt_block(input logic [127:0] s_in);
    logic [127:0] s;
    logic [7:0]   t [16];
    logic [7:0]   a0, a1, a2, a3;
    s = s_in ^ round_keys[0];
    for (int rnd = 1; rnd <= ROUND_COUNT; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          t[4*c+r] = subst[s[8*(4*((c+r)%4)+r) +: 8]];
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        if (rnd < ROUND_COUNT) begin
          s[8*(4*c)   +: 8] = gf_double(a0) ^ gf_double(a1) ^ a1 ^ a2 ^ a3;
          s[8*(4*c+1) +: 8] = a0 ^ gf_double(a1) ^ gf_double(a2) ^ a2 ^ a3;
          s[8*(4*c+2) +: 8] = a0 ^ a1 ^ gf_double(a2) ^ gf_double(a3) ^ a3;
          s[8*(4*c+3) +: 8] = gf_double(a0) ^ a0 ^ a1 ^ a2 ^ gf_double(a3);
        end else begin
          s[8*(4*c) +: 32] = {a3, a2, a1, a0};
        end
      end
      s = s ^ round_keys[rnd];
    end
    return s;
  endfunction

  // Works out the result of one request and advances the feedback.
  task automatic predict_block(input logic [127:0] data, input logic [4:0] cnt,
                               input logic first);
    logic [127:0] stream, plain_out, cipher_in;
    int           valid_bytes;
    res_t         r;
    valid_bytes = (cnt > BLOCK_BYTES) ? BLOCK_BYTES : cnt;
    if (first) begin
      chain_block = iv_shadow;
      expand_round_keys();
    end
    stream    = encrypt_block(chain_block);
    plain_out = '0;
    cipher_in = '0;
    for (int i = 0; i < valid_bytes; i++) begin
      plain_out[8*i +: 8] = data[8*i +: 8] ^ stream[8*i +: 8];
      cipher_in[8*i +: 8] = data[8*i +: 8];
    end
    chain_block    = decrypting ? cipher_in : plain_out;
    r.result_low   = plain_out[63:0];
    r.result_high  = plain_out[127:64];
    r.result_count = 5'(valid_bytes);
    owed_results.push_back(r);
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      key_shadow  = '0;
      iv_shadow   = '0;
      decrypting  = 1'b0;
      chain_block = '0;
      fail_count  = 0;
      owed_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (owed_results.size() == 0) begin
          $display("%0t: result with none expected: low %h high %h count %0d", $time,
                   out_mon.result_low, out_mon.result_high, out_mon.result_count);
          fail_count = fail_count + 1;
        end else begin
          want = owed_results.pop_front();
          if (out_mon.result_low !== want.result_low) begin
            $display("%0t: result_low expected %h actual %h", $time,
                     want.result_low, out_mon.result_low);
            fail_count = fail_count + 1;
          end
          if (out_mon.result_high !== want.result_high) begin
            $display("%0t: result_high expected %h actual %h", $time,
                     want.result_high, out_mon.result_high);
            fail_count = fail_count + 1;
          end
          if (out_mon.result_count !== want.result_count) begin
            $display("%0t: result_count expected %0d actual %0d", $time,
                     want.result_count, out_mon.result_count);
            fail_count = fail_count + 1;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        predict_block({in_mon.data_high, in_mon.data_low}, in_mon.byte_count,
                      in_mon.first_block);
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY_LOW:  key_shadow[63:0]   = cfg_data;
          REG_KEY_HIGH: key_shadow[127:64] = cfg_data;
          REG_IV_LOW:   iv_shadow[63:0]    = cfg_data;
          REG_IV_HIGH:  iv_shadow[127:64]  = cfg_data;
          REG_DECRYPT:  decrypting         = cfg_data[0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== tb/aes128_cfb_cipher_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aes128_cfb_cipher_tb: stimulus and verdict for the AES-128 CFB block
// Streams of blocks under changing keys, IVs and directions, with random
// stalls on both channels; a checker predicts and compares every result.
// ----------------------------------------------------------------------------
module aes128_cfb_cipher_tb
  import acfb_pkg::*;
;

  localparam int RANDOM_REQUESTS = 2000;
  // A first block adds a key expansion pass, and both sides stall at random;
  // the limit is several times the slowest correct run.
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int DRAIN_CYCLES    = 60;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  int          fail_count;
  int          results_owed;
  int          cycle_count;
  int          sent;
  logic        calm;          // set for the last part of the run: no idling
  logic        request_taken; // request accepted at the last rising edge
  int          ready_hold;

  acfb_in_if  in_ch();
  acfb_out_if out_ch();

  aes128_cfb_cipher dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  acfb_cfb_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The handshake is captured on the rising edge so that the driver, which
  // works on the falling edge, sees a settled acceptance flag.
  always @(posedge clk) begin
    request_taken <= in_ch.valid && in_ch.ready;
    cycle_count   <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // The result side stalls in bursts of random length, with stretches
  // of steady readiness in between.
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      ready_hold   <= $urandom_range(0, 10);
    end else begin
      out_ch.ready <= 1'b1;
      ready_hold   <= $urandom_range(0, 20);
    end
  end

  // Called and returns at a falling edge, after acceptance and any sender gap.
  task automatic send_request(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [4:0] cnt, input logic first);
    in_ch.valid       <= 1'b1;
    in_ch.data_low    <= lo;
    in_ch.data_high   <= hi;
    in_ch.byte_count  <= cnt;
    in_ch.first_block <= first;
    forever begin
      @(negedge clk);
      if (request_taken) break;
    end
    sent++;
    // Sender gap, sometimes, so idle cycles land on every phase of a block.
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
  endtask

  task automatic send_random_data(input logic [4:0] cnt, input logic first);
    send_request({$urandom, $urandom}, {$urandom, $urandom}, cnt, first);
  endtask

  // Lowers valid and waits until every result is back; the block is idle then.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (results_owed != 0);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  task automatic load_settings(input logic [127:0] key, input logic [127:0] iv,
                               input logic dir);
    write_reg(REG_KEY_LOW,  key[63:0]);
    write_reg(REG_KEY_HIGH, key[127:64]);
    write_reg(REG_IV_LOW,   iv[63:0]);
    write_reg(REG_IV_HIGH,  iv[127:64]);
    write_reg(REG_DECRYPT,  {63'd0, dir});
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [127:0] pick_wide();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom, $urandom, $urandom};
    endcase
  endfunction

  initial begin
    int stream_len;
    logic [4:0] cnt;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = REG_KEY_LOW;
    cfg_data          = '0;
    calm              = 1'b0;
    sent              = 0;
    cycle_count       = 0;
    ready_hold        = 0;
    request_taken     = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.data_low    = '0;
    in_ch.data_high   = '0;
    in_ch.byte_count  = 5'd16;
    in_ch.first_block = 1'b0;
    out_ch.ready      = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. The reset settings (all-zero key and IV) are used first,
    // and the stream always opens with a first block so the key store is
    // written before it is read.
    send_request('0, '0, 5'd16, 1'b1);
    send_request('1, '1, 5'd16, 1'b0);
    send_request(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 5'd16, 1'b0);
    send_request(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 5'd1, 1'b0);
    // A first block in the middle of a stream restarts the chain.
    send_request('1, '1, 5'd15, 1'b1);
    // A zero count yields an all-zero result and an all-zero feedback.
    send_request('1, '1, 5'd0, 1'b0);
    // Counts above sixteen behave as a full block.
    send_request('1, '0, 5'd17, 1'b0);
    send_request('0, '1, 5'd31, 1'b0);
    // Hold off until every result is back before reconfiguring.
    drain();
    load_settings('1, '1, 1'b1);
    send_request('0, '0, 5'd16, 1'b1);
    send_request('1, '1, 5'd16, 1'b0);
    send_request(64'h0123_4567_89AB_CDEF, '1, 5'd8, 1'b0);
    send_request('1, '1, 5'd9, 1'b0);
    send_request('1, '0, 5'd31, 1'b0);
    send_request('0, '0, 5'd0, 1'b0);
    drain();
    load_settings({$urandom, $urandom, $urandom, $urandom},
                  {$urandom, $urandom, $urandom, $urandom}, 1'b0);
    send_request('1, '1, 5'd16, 1'b1);
    send_request('0, '1, 5'd1, 1'b0);
    send_request('1, '0, 5'd17, 1'b0);

    // Random part: phases of fresh settings, each carrying a few streams of
    // well-formed messages, with some malformed requests mixed in.
    while (sent < RANDOM_REQUESTS + 20) begin
      drain();
      load_settings(pick_wide(), pick_wide(), 1'($urandom_range(0, 1)));
      repeat ($urandom_range(1, 4)) begin
        stream_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(1, 10);
        for (int i = 0; i < stream_len; i++) begin
          if (sent > RANDOM_REQUESTS * 9 / 10 + 20) calm = 1'b1;
          if (i == stream_len - 1)
            cnt = 5'($urandom_range(1, 16));
          else
            cnt = 5'd16;
          if (i != 0 && $urandom_range(0, 9) == 0)
            send_random_data(5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
          else
            send_random_data(cnt, i == 0);
        end
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && results_owed == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/acfb_pkg.sv
hdl/acfb_stream_if.sv
hdl/acfb_ram.sv
hdl/aes128_cfb_cipher.sv
tb/acfb_cfb_checker.sv
tb/aes128_cfb_cipher_tb.sv
